/* sv/clgp_pkg.sv */
// Shared constants, register codes and types of the clipped line pixel generator.
package clgp_pkg;

    localparam int COORD_BITS     = 12;
    localparam int FRAME_BITS     = 12;
    localparam int ADDR_BITS      = 22;
    localparam int COLOR_BITS     = 32;
    localparam int QUEUE_DEPTH    = 4;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RESET  = 12'd640;
    localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RESET = 12'd480;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    // Frame size as seen by the stepper.
    typedef struct packed {
        logic [FRAME_BITS-1:0] width;
        logic [FRAME_BITS-1:0] height;
    } frame_cfg_t;

    // Classified item at the default coordinate width; the top level builds
    // the same layout at its own coordinate width.
    typedef struct packed {
        logic                    is_load;
        logic                    active;
        logic                    x_negative;
        logic                    y_negative;
        logic                    x_is_major;
        logic [COORD_BITS-1:0]   start_x;
        logic [COORD_BITS-1:0]   start_y;
        logic [COORD_BITS-1:0]   end_x;
        logic [COORD_BITS-1:0]   end_y;
        logic [COORD_BITS:0]     abs_dx;
        logic [COORD_BITS:0]     abs_dy;
        logic [COORD_BITS+2:0]   error_term;
        logic [COLOR_BITS-1:0]   color;
    } line_setup_t;

endpackage

/* sv/clgp_cmd_if.sv */
// Command channel: line loads and step requests.
interface clgp_cmd_if #(
    parameter int COORD_BITS = clgp_pkg::COORD_BITS
) ();
    logic                              valid;
    logic                              ready;
    logic                              operation;
    logic signed [COORD_BITS-1:0]      start_x;
    logic signed [COORD_BITS-1:0]      start_y;
    logic signed [COORD_BITS-1:0]      end_x;
    logic signed [COORD_BITS-1:0]      end_y;
    logic [clgp_pkg::COLOR_BITS-1:0]   line_color;

    modport source (
        output valid, operation, start_x, start_y, end_x, end_y, line_color,
        input  ready
    );

    modport sink (
        input  valid, operation, start_x, start_y, end_x, end_y, line_color,
        output ready
    );
endinterface

/* sv/clgp_pixel_if.sv */
// Pixel channel: one produced pixel per item.
interface clgp_pixel_if #(
    parameter int COORD_BITS = clgp_pkg::COORD_BITS
) ();
    logic                              valid;
    logic                              ready;
    logic                              pixel_valid;
    logic                              in_frame;
    logic signed [COORD_BITS-1:0]      pixel_x;
    logic signed [COORD_BITS-1:0]      pixel_y;
    logic [clgp_pkg::ADDR_BITS-1:0]    pixel_address;
    logic [clgp_pkg::COLOR_BITS-1:0]   pixel_color;
    logic                              last_pixel;

    modport source (
        output valid, pixel_valid, in_frame, pixel_x, pixel_y, pixel_address,
               pixel_color, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_valid, in_frame, pixel_x, pixel_y, pixel_address,
               pixel_color, last_pixel,
        output ready
    );
endinterface

/* sv/clgp_front.sv */
// Front end: accepts command items, classifies them and works out line setup.
module clgp_front #(
    parameter int  COORD_BITS = clgp_pkg::COORD_BITS,
    parameter type setup_t    = clgp_pkg::line_setup_t
) (
    clgp_cmd_if.sink cmd,
    input  logic     q_full,
    output logic     q_push,
    output setup_t   q_data
);
    localparam int DW = COORD_BITS + 1;
    localparam int EW = COORD_BITS + 3;

    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic [DW-1:0]        adx;
    logic [DW-1:0]        ady;
    logic [DW-1:0]        major;
    logic [DW-1:0]        minor;
    logic                 x_major;
    logic [EW-1:0]        err;

    always_comb
    begin
        dx = $signed({cmd.end_x[COORD_BITS-1], cmd.end_x})
           - $signed({cmd.start_x[COORD_BITS-1], cmd.start_x});
        dy = $signed({cmd.end_y[COORD_BITS-1], cmd.end_y})
           - $signed({cmd.start_y[COORD_BITS-1], cmd.start_y});
        adx = dx[DW-1] ? DW'(-dx) : DW'(dx);
        ady = dy[DW-1] ? DW'(-dy) : DW'(dy);
        x_major = adx > ady;
        major = x_major ? adx : ady;
        minor = x_major ? ady : adx;
        // Error starts at twice the minor delta less the major delta.
        err = {1'b0, minor, 1'b0} - {2'b00, major};
    end

    always_comb
    begin
        q_data            = '0;
        q_data.is_load    = (cmd.operation == clgp_pkg::OP_LOAD);
        q_data.active     = (adx != '0) || (ady != '0);
        q_data.x_negative = dx[DW-1] || (dx == '0);
        q_data.y_negative = dy[DW-1] || (dy == '0);
        q_data.x_is_major = x_major;
        q_data.start_x    = cmd.start_x;
        q_data.start_y    = cmd.start_y;
        q_data.end_x      = cmd.end_x;
        q_data.end_y      = cmd.end_y;
        q_data.abs_dx     = adx;
        q_data.abs_dy     = ady;
        q_data.error_term = err;
        q_data.color      = cmd.line_color;
    end

    assign cmd.ready = !q_full;
    assign q_push    = cmd.valid && !q_full;
endmodule

/* sv/clgp_queue.sv */
// Short first-in first-out queue between the front end and the stepper.
module clgp_queue #(
    parameter type data_t = logic,
    parameter int  DEPTH  = clgp_pkg::QUEUE_DEPTH
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  data_t push_data,
    output logic  full,
    input  logic  pop,
    output data_t pop_data,
    output logic  not_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    data_t          store_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg;
    logic [PW-1:0]  wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg;
    logic [PW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = store_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

/* sv/clgp_back.sv */
// Back end: the line stepper with clipping, addressing and the output register.
module clgp_back #(
    parameter int  COORD_BITS = clgp_pkg::COORD_BITS,
    parameter type setup_t    = clgp_pkg::line_setup_t
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  clgp_pkg::frame_cfg_t cfg,
    input  logic                 q_valid,
    input  setup_t               q_data,
    output logic                 q_pop,
    clgp_pixel_if.source         pixel
);
    localparam int W  = COORD_BITS;
    localparam int DW = COORD_BITS + 1;
    localparam int EW = COORD_BITS + 3;
    localparam int FB = clgp_pkg::FRAME_BITS;
    localparam int AB = clgp_pkg::ADDR_BITS;
    localparam int CB = clgp_pkg::COLOR_BITS;
    localparam int MW = (W > FB) ? W : FB;

    // Line state.
    logic [W-1:0]   cur_x_reg;
    logic [W-1:0]   cur_y_reg;
    logic [W-1:0]   stop_x_reg;
    logic [W-1:0]   stop_y_reg;
    logic [DW-1:0]  abs_dx_reg;
    logic [DW-1:0]  abs_dy_reg;
    logic           x_negative_reg;
    logic           y_negative_reg;
    logic           x_is_major_reg;
    logic [EW-1:0]  error_reg;
    logic [CB-1:0]  color_reg;
    logic           active_reg;
    logic           active_next;

    // Output register.
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           out_in_frame_reg;
    logic [W-1:0]   out_x_reg;
    logic [W-1:0]   out_y_reg;
    logic [AB-1:0]  out_addr_reg;
    logic [CB-1:0]  out_color_reg;
    logic           out_last_reg;

    logic           take;
    logic           produce;
    logic [W-1:0]   step_x;
    logic [W-1:0]   step_y;
    logic [EW-1:0]  err_add;
    logic [EW-1:0]  err_new;
    logic           minor_step;
    logic [W-1:0]   new_x;
    logic [W-1:0]   new_y;
    logic           last;
    logic           in_frame_now;
    logic [AB-1:0]  addr;

    assign take    = q_valid && (!out_valid_reg || pixel.ready);
    assign q_pop   = take;
    assign produce = take && !q_data.is_load && active_reg;

    always_comb
    begin
        step_x = x_negative_reg ? cur_x_reg - 1'b1 : cur_x_reg + 1'b1;
        step_y = y_negative_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
        err_add = error_reg + (x_is_major_reg ? {2'b00, abs_dy_reg} : {2'b00, abs_dx_reg});
        // The x-major case needs a strictly positive error, the y-major case
        // steps on zero as well.
        if (x_is_major_reg)
        begin
            minor_step = !err_add[EW-1] && (err_add != '0);
        end
        else
        begin
            minor_step = !err_add[EW-1];
        end
        if (minor_step)
        begin
            err_new = err_add - (x_is_major_reg ? {2'b00, abs_dx_reg}
                                                : {2'b00, abs_dy_reg});
        end
        else
        begin
            err_new = err_add;
        end
        new_x = (x_is_major_reg || minor_step) ? step_x : cur_x_reg;
        new_y = (!x_is_major_reg || minor_step) ? step_y : cur_y_reg;
        last  = x_is_major_reg ? (new_x == stop_x_reg) : (new_y == stop_y_reg);
    end

    always_comb
    begin
        in_frame_now = !cur_x_reg[W-1] && !cur_y_reg[W-1]
                    && (MW'(cur_x_reg) < MW'(cfg.width))
                    && (MW'(cur_y_reg) < MW'(cfg.height));
        addr = in_frame_now ? AB'(AB'(cfg.width) * AB'(cur_y_reg)) + AB'(cur_x_reg) : '0;
    end

    always_comb
    begin
        active_next = active_reg;
        if (take)
        begin
            if (q_data.is_load)
            begin
                active_next = q_data.active;
            end
            else if (active_reg && last)
            begin
                active_next = 1'b0;
            end
        end
        if (take)
        begin
            out_valid_next = produce;
        end
        else
        begin
            out_valid_next = out_valid_reg && !pixel.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && q_data.is_load)
        begin
            cur_x_reg      <= q_data.start_x;
            cur_y_reg      <= q_data.start_y;
            stop_x_reg     <= q_data.end_x;
            stop_y_reg     <= q_data.end_y;
            abs_dx_reg     <= q_data.abs_dx;
            abs_dy_reg     <= q_data.abs_dy;
            x_negative_reg <= q_data.x_negative;
            y_negative_reg <= q_data.y_negative;
            x_is_major_reg <= q_data.x_is_major;
            error_reg      <= q_data.error_term;
            color_reg      <= q_data.color;
        end
        else if (produce)
        begin
            cur_x_reg <= new_x;
            cur_y_reg <= new_y;
            error_reg <= err_new;
        end

        if (produce)
        begin
            out_in_frame_reg <= in_frame_now;
            out_x_reg        <= cur_x_reg;
            out_y_reg        <= cur_y_reg;
            out_addr_reg     <= addr;
            out_color_reg    <= color_reg;
            out_last_reg     <= last;
        end
    end

    assign pixel.valid         = out_valid_reg;
    assign pixel.pixel_valid   = 1'b1;
    assign pixel.in_frame      = out_in_frame_reg;
    assign pixel.pixel_x       = out_x_reg;
    assign pixel.pixel_y       = out_y_reg;
    assign pixel.pixel_address = out_addr_reg;
    assign pixel.pixel_color   = out_color_reg;
    assign pixel.last_pixel    = out_last_reg;
endmodule

/* sv/clipped_line_pixel_generator.sv */
// Top level of the clipped line pixel generator.
//
// Usage: items arrive on the cmd channel. An item with operation zero loads a
// line (start point, end point, color) and produces nothing; an item with
// operation one asks for one step and produces one item on the pixel channel
// while a line is in progress, and nothing otherwise. Each pixel carries its
// position, whether it lies inside the frame, its linear address
// frame_width*y+x (zero outside the frame), the line color and a flag on the
// final pixel. The end point itself is never drawn.
// The frame size is set through the write port (cfg_we, cfg_index, cfg_data)
// while the block is idle, a rule on the user that the block itself does not
// enforce; the frame resets to 640 by 480. Throughput: one item per clock
// while the pixel channel does not stall. The front end classifies each item
// and computes the line setup, a four-entry queue carries it to the stepper,
// and the stepper retires one queued item per clock to its output register.
// When the receiver stalls, the pixel waits in the output register, the queue
// fills and cmd.ready drops once it is full; nothing is lost.
// Reset empties the queue, drops any pending pixel and leaves no line active.
module clipped_line_pixel_generator #(
    parameter int COORD_BITS = clgp_pkg::COORD_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [clgp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [clgp_pkg::FRAME_BITS-1:0]      cfg_data,
    clgp_cmd_if.sink                             cmd,
    clgp_pixel_if.source                         pixel
);
    // Same layout as the package's setup type, at this coordinate width.
    typedef struct packed {
        logic                              is_load;
        logic                              active;
        logic                              x_negative;
        logic                              y_negative;
        logic                              x_is_major;
        logic [COORD_BITS-1:0]             start_x;
        logic [COORD_BITS-1:0]             start_y;
        logic [COORD_BITS-1:0]             end_x;
        logic [COORD_BITS-1:0]             end_y;
        logic [COORD_BITS:0]               abs_dx;
        logic [COORD_BITS:0]               abs_dy;
        logic [COORD_BITS+2:0]             error_term;
        logic [clgp_pkg::COLOR_BITS-1:0]   color;
    } setup_t;

    clgp_pkg::frame_cfg_t cfg_reg;
    clgp_pkg::frame_cfg_t cfg_next;

    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_valid;
    setup_t q_in;
    setup_t q_out;

    // Frame size registers; an unknown index leaves both unchanged.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                clgp_pkg::REG_FRAME_WIDTH:  cfg_next.width  = cfg_data;
                clgp_pkg::REG_FRAME_HEIGHT: cfg_next.height = cfg_data;
                default:                    cfg_next        = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= clgp_pkg::FRAME_WIDTH_RESET;
            cfg_reg.height <= clgp_pkg::FRAME_HEIGHT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    clgp_front #(
        .COORD_BITS (COORD_BITS),
        .setup_t    (setup_t)
    ) u_front (
        .cmd    (cmd),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    clgp_queue #(
        .data_t (setup_t),
        .DEPTH  (clgp_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .not_empty (q_valid)
    );

    clgp_back #(
        .COORD_BITS (COORD_BITS),
        .setup_t    (setup_t)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .pixel   (pixel)
    );
endmodule
